FILE: src/lseg_pkg.sv
`default_nettype none
package lseg_pkg;

  // Strip geometry and fade length
  localparam int PIXEL_COUNT = 60;
  localparam int FADE_STEPS  = 50;

  localparam int PIX_W      = 6;
  localparam int STEP_W     = 6;
  localparam int CH_W       = 8;
  localparam int NCH        = 3;
  localparam int FADE_DIV   = FADE_STEPS - 1;
  localparam int PROD_W     = STEP_W + CH_W;
  localparam int RB_STRIDE  = 256 / PIXEL_COUNT;

  // Divide by FADE_DIV as a reciprocal multiply, q = (x * FADE_RECIP) >> FADE_SHIFT;
  // exact for every step * channel difference product
  localparam int FADE_SHIFT = 20;
  localparam int RECIP_W    = FADE_SHIFT + 1;
  localparam int MUL_W      = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] FADE_RECIP = RECIP_W'((1 << FADE_SHIFT) / FADE_DIV + 1);

  localparam logic [7:0] GREY_LEVEL  = 8'd50;
  localparam logic [2:0] GRID_ROWS   = 3'd7;
  localparam logic [2:0] STRIPE_WRAP = 3'd7;
  localparam logic [7:0] WHEEL_SEG1  = 8'd85;
  localparam logic [7:0] WHEEL_SEG2  = 8'd170;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STANDBY = 3'd4;

  // Lamp modes
  localparam logic [2:0] MODE_COLOUR  = 3'd0;
  localparam logic [2:0] MODE_TWINKLE = 3'd1;
  localparam logic [2:0] MODE_RAINBOW = 3'd2;
  localparam logic [2:0] MODE_CYCLE   = 3'd3;
  localparam logic [2:0] MODE_STRIPE  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT,
    ST_PIX
  } lseg_state_e;

  // Index 0 red, 1 green, 2 blue
  typedef logic [NCH-1:0][CH_W-1:0] rgb_t;

  function automatic rgb_t wheel(input logic [7:0] pos);
    logic [7:0] q;
    logic [7:0] qq;
    logic [7:0] q3;
    rgb_t c;
    q = 8'd255 - pos;
    if (q < WHEEL_SEG1) begin
      qq = q;
    end else if (q < WHEEL_SEG2) begin
      qq = q - WHEEL_SEG1;
    end else begin
      qq = q - WHEEL_SEG2;
    end
    q3 = qq + {qq[6:0], 1'b0};
    c = '0;
    if (q < WHEEL_SEG1) begin
      c[0] = 8'd255 - q3;
      c[2] = q3;
    end else if (q < WHEEL_SEG2) begin
      c[1] = q3;
      c[2] = 8'd255 - q3;
    end else begin
      c[0] = q3;
      c[1] = 8'd255 - q3;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/led_strip_effect_generator.sv
// Whole-strip results (standby, cycle) pass through ST_EMIT and then the output register; pixel
//   transfers through ST_PIX; a fade result through ST_MUL and ST_DIV per channel (one shared
//   multiplier, per channel a step*difference pass then a reciprocal pass for the divide by 49).
// A new tick is taken only once the previous one is done (in_stall_o is high outside ST_IDLE);
//   rainbow/stripe send 60 pixels, one per cycle while the output does not stall.
// Reset (rst_ni low, asynchronous): mode stripe, targets and colours black, counters zero.
`default_nettype none
module led_strip_effect_generator import lseg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // tick channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  tick_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [PIX_W-1:0]           pixel_index_o,
  output logic [CH_W-1:0]            red_out_o,
  output logic [CH_W-1:0]            green_out_o,
  output logic [CH_W-1:0]            blue_out_o,
  output logic                       whole_strip_o,
  output logic                       last_of_frame_o,
  // configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Sequencer
  lseg_state_e state_q, state_d;

  // Configuration registers
  logic [2:0]        cfg_mode_q, cfg_mode_d;
  rgb_t              cfg_tgt_q, cfg_tgt_d;
  logic              cfg_stby_q, cfg_stby_d;

  // Animation state
  rgb_t              seen_tgt_q, seen_tgt_d;
  rgb_t              fade_start_q, fade_start_d;
  rgb_t              shown_q, shown_d;
  logic [STEP_W-1:0] fade_step_q, fade_step_d;
  logic              fade_done_q, fade_done_d;
  logic [2:0]        seen_mode_q, seen_mode_d;
  logic              seen_stby_q, seen_stby_d;
  logic [7:0]        cyc_pos_q, cyc_pos_d;
  logic [7:0]        rb_off_q, rb_off_d;
  logic [2:0]        stripe_col_q, stripe_col_d;

  // Job control
  logic [1:0]        ch_q, ch_d;
  logic [PIX_W-1:0]  pix_q, pix_d;
  logic              rainbow_q, rainbow_d;

  // Shared multiplier datapath (no reset)
  logic [PROD_W-1:0] dvd_q, dvd_d;
  logic              neg_q, neg_d;
  rgb_t              emit_q, emit_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [PIX_W-1:0]  opix_q, opix_d;
  rgb_t              orgb_q, orgb_d;
  logic              owhole_q, owhole_d;
  logic              olast_q, olast_d;

  logic slot_free;
  assign slot_free = !out_valid_q || !out_stall_i;

  assign in_stall_o      = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign pixel_index_o   = opix_q;
  assign red_out_o       = orgb_q[0];
  assign green_out_o     = orgb_q[1];
  assign blue_out_o      = orgb_q[2];
  assign whole_strip_o   = owhole_q;
  assign last_of_frame_o = olast_q;

  // Combinational helpers
  logic                restart;
  logic                done_eff;
  rgb_t                wheel_cyc;
  rgb_t                pix_rgb;
  logic [7:0]          rb_pos;
  logic                lit;
  logic [CH_W-1:0]     ch_s;
  logic [CH_W-1:0]     ch_t;
  logic [CH_W-1:0]     mag;
  logic [PROD_W-1:0]   mul_a;
  logic [RECIP_W-1:0]  mul_b;
  logic [MUL_W-1:0]    mul_p;
  logic [PROD_W-1:0]   quot;
  logic [CH_W-1:0]     fade_v;
  logic [STEP_W:0]     step_nxt;
  logic [2:0]          col_nxt;

  always_comb begin
    // Fade restart: new target, entry into colour mode, or standby entry in colour mode
    restart = (cfg_tgt_q != seen_tgt_q)
           || ((cfg_mode_q != seen_mode_q) && (cfg_mode_q == MODE_COLOUR))
           || (!seen_stby_q && cfg_stby_q && (cfg_mode_q == MODE_COLOUR));
    done_eff  = restart ? 1'b0 : fade_done_q;
    wheel_cyc = wheel(cyc_pos_q);

    // Per-pixel colour
    rb_pos  = 8'(32'(pix_q) * RB_STRIDE) + rb_off_q;
    lit     = (pix_q[PIX_W-1:3] < GRID_ROWS) && (pix_q[2:0] == stripe_col_q);
    if (rainbow_q) begin
      pix_rgb = wheel(rb_pos);
    end else begin
      pix_rgb = lit ? {NCH{GREY_LEVEL}} : '0;
    end

    // Fade channel operands
    ch_s = fade_start_q[ch_q];
    ch_t = seen_tgt_q[ch_q];
    mag  = (ch_t < ch_s) ? (ch_s - ch_t) : (ch_t - ch_s);

    // One multiplier: step * |difference| first, then times the reciprocal of FADE_DIV
    if (state_q == ST_DIV) begin
      mul_a = dvd_q;
      mul_b = FADE_RECIP;
    end else begin
      mul_a = PROD_W'(fade_step_q);
      mul_b = RECIP_W'(mag);
    end
    mul_p  = MUL_W'(mul_a) * MUL_W'(mul_b);
    quot   = PROD_W'(mul_p >> FADE_SHIFT);
    fade_v = neg_q ? (ch_s - quot[CH_W-1:0]) : (ch_s + quot[CH_W-1:0]);

    step_nxt = (STEP_W+1)'(fade_step_q) + (STEP_W+1)'(1);
    col_nxt  = stripe_col_q + 3'd1;
  end

  always_comb begin
    state_d      = state_q;
    cfg_mode_d   = cfg_mode_q;
    cfg_tgt_d    = cfg_tgt_q;
    cfg_stby_d   = cfg_stby_q;
    seen_tgt_d   = seen_tgt_q;
    fade_start_d = fade_start_q;
    shown_d      = shown_q;
    fade_step_d  = fade_step_q;
    fade_done_d  = fade_done_q;
    seen_mode_d  = seen_mode_q;
    seen_stby_d  = seen_stby_q;
    cyc_pos_d    = cyc_pos_q;
    rb_off_d     = rb_off_q;
    stripe_col_d = stripe_col_q;
    ch_d         = ch_q;
    pix_d        = pix_q;
    rainbow_d    = rainbow_q;
    dvd_d        = dvd_q;
    neg_d        = neg_q;
    emit_d       = emit_q;
    out_valid_d  = out_valid_q && out_stall_i;
    opix_d       = opix_q;
    orgb_d       = orgb_q;
    owhole_d     = owhole_q;
    olast_d      = olast_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:    cfg_mode_d   = cfg_data_i[2:0];
        REG_RED:     cfg_tgt_d[0] = cfg_data_i;
        REG_GREEN:   cfg_tgt_d[1] = cfg_data_i;
        REG_BLUE:    cfg_tgt_d[2] = cfg_data_i;
        REG_STANDBY: cfg_stby_d   = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && tick_i) begin
          seen_tgt_d  = cfg_tgt_q;
          seen_mode_d = cfg_mode_q;
          seen_stby_d = cfg_stby_q;
          if (restart) begin
            fade_start_d = shown_q;
            fade_step_d  = '0;
            fade_done_d  = 1'b0;
          end
          if (cfg_stby_q) begin
            emit_d  = '0;
            state_d = ST_EMIT;
          end else begin
            case (cfg_mode_q)
              MODE_COLOUR: begin
                if (!done_eff) begin
                  ch_d    = 2'd0;
                  state_d = ST_MUL;
                end
              end
              MODE_TWINKLE: ;
              MODE_RAINBOW: begin
                pix_d     = '0;
                rainbow_d = 1'b1;
                state_d   = ST_PIX;
              end
              MODE_CYCLE: begin
                shown_d   = wheel_cyc;
                emit_d    = wheel_cyc;
                cyc_pos_d = cyc_pos_q + 8'd1;
                state_d   = ST_EMIT;
              end
              default: begin
                // stripe, and the unused codes
                pix_d     = '0;
                rainbow_d = 1'b0;
                state_d   = ST_PIX;
              end
            endcase
          end
        end
      end
      ST_MUL: begin
        dvd_d   = mul_p[PROD_W-1:0];
        neg_d   = (ch_t < ch_s);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        shown_d[ch_q] = fade_v;
        emit_d[ch_q]  = fade_v;
        if (ch_q == 2'(NCH - 1)) begin
          if (step_nxt >= (STEP_W+1)'(FADE_STEPS)) begin
            fade_done_d = 1'b1;
            fade_step_d = '0;
          end else begin
            fade_step_d = step_nxt[STEP_W-1:0];
          end
          state_d = ST_EMIT;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          opix_d      = '0;
          orgb_d      = emit_q;
          owhole_d    = 1'b1;
          olast_d     = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_PIX: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          opix_d      = pix_q;
          orgb_d      = pix_rgb;
          owhole_d    = 1'b0;
          olast_d     = (pix_q == PIX_W'(PIXEL_COUNT - 1));
          pix_d       = pix_q + PIX_W'(1);
          if (pix_q == PIX_W'(PIXEL_COUNT - 1)) begin
            if (rainbow_q) begin
              rb_off_d = rb_off_q + 8'd1;
            end else begin
              stripe_col_d = (col_nxt >= STRIPE_WRAP) ? 3'd0 : col_nxt;
            end
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_mode_q   <= MODE_STRIPE;
      cfg_tgt_q    <= '0;
      cfg_stby_q   <= 1'b0;
      seen_tgt_q   <= '0;
      fade_start_q <= '0;
      shown_q      <= '0;
      fade_step_q  <= '0;
      fade_done_q  <= 1'b0;
      seen_mode_q  <= MODE_STRIPE;
      seen_stby_q  <= 1'b0;
      cyc_pos_q    <= '0;
      rb_off_q     <= '0;
      stripe_col_q <= '0;
      ch_q         <= '0;
      pix_q        <= '0;
      rainbow_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cfg_mode_q   <= cfg_mode_d;
      cfg_tgt_q    <= cfg_tgt_d;
      cfg_stby_q   <= cfg_stby_d;
      seen_tgt_q   <= seen_tgt_d;
      fade_start_q <= fade_start_d;
      shown_q      <= shown_d;
      fade_step_q  <= fade_step_d;
      fade_done_q  <= fade_done_d;
      seen_mode_q  <= seen_mode_d;
      seen_stby_q  <= seen_stby_d;
      cyc_pos_q    <= cyc_pos_d;
      rb_off_q     <= rb_off_d;
      stripe_col_q <= stripe_col_d;
      ch_q         <= ch_d;
      pix_q        <= pix_d;
      rainbow_q    <= rainbow_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    neg_q    <= neg_d;
    emit_q   <= emit_d;
    opix_q   <= opix_d;
    orgb_q   <= orgb_d;
    owhole_q <= owhole_d;
    olast_q  <= olast_d;
  end

  // Assertions
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (STEP_W+1)'(fade_step_q) < (STEP_W+1)'(FADE_STEPS))
    else $error("fade step out of range");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stripe_col_q < STRIPE_WRAP)
    else $error("stripe column out of range");

  a_fade_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV) |-> (ch_q < 2'(NCH)))
    else $error("fade channel out of range");

  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && slot_free) |=> (out_valid_q && olast_q && owhole_q))
    else $error("whole-strip transfer not loaded as last of frame");

  a_whole_pix0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && owhole_q) |-> (opix_q == '0 && olast_q))
    else $error("whole-strip result with pixel index or not last");

endmodule
`default_nettype wire

FILE: verif/tb_led_strip_effect_generator.sv
`timescale 1ns / 1ps

module tb_led_strip_effect_generator;
  import lseg_pkg::*;

  // One write toward the strip as the block reports it
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    rgb_t             rgb;
    logic             whole;
    logic             last;
  } strip_write_t;

  localparam int SETTLE_CYCLES = 60;   // idle margin between phases
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int RANDOM_TICKS  = 78;

  // ---------------------------------------------------------------------
  // DUT signals; the inputs are known from time zero
  // ---------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  tick_i      = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      pixel_index_o;
  logic [CH_W-1:0]       red_out_o;
  logic [CH_W-1:0]       green_out_o;
  logic [CH_W-1:0]       blue_out_o;
  logic                  whole_strip_o;
  logic                  last_of_frame_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  led_strip_effect_generator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .tick_i         (tick_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_index_o  (pixel_index_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .whole_strip_o  (whole_strip_o),
    .last_of_frame_o(last_of_frame_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------
  logic         tick_q[$];      // ticks waiting to be offered
  strip_write_t pending_px[$];  // predicted strip writes, oldest first
  bit           no_idle   = 1'b0;
  int           hold_req  = 0;  // bumped by the sequencer to ask for a hold-off
  int           mismatches = 0;
  int           n_ticks    = 0;
  int           n_results  = 0;
  int           n_writes   = 0;

  // Shadow of the configuration registers
  logic [2:0] cfg_mode  = MODE_STRIPE;
  rgb_t       cfg_rgb   = '0;
  logic       cfg_stby  = 1'b0;

  // Shadow of the effect engine state
  rgb_t       seen_rgb   = '0;
  rgb_t       fade_from  = '0;
  rgb_t       shown_rgb  = '0;
  int         fade_pos   = 0;
  bit         fade_over  = 1'b0;
  logic [2:0] seen_mode  = MODE_STRIPE;
  logic       seen_stby  = 1'b0;
  logic [7:0] wheel_pos  = '0;
  logic [7:0] rb_off     = '0;
  int         stripe_col = 0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic rgb_t colour_wheel(input logic [7:0] pos);
    int   q;
    rgb_t c;
    q = 255 - int'(pos);
    c = '0;
    if (q < 85) begin
      c[0] = 8'(255 - 3 * q);
      c[2] = 8'(3 * q);
    end else if (q < 170) begin
      q -= 85;
      c[1] = 8'(3 * q);
      c[2] = 8'(255 - 3 * q);
    end else begin
      q -= 170;
      c[0] = 8'(3 * q);
      c[1] = 8'(255 - 3 * q);
    end
    return c;
  endfunction

  function automatic void restart_fade();
    fade_from = shown_rgb;
    fade_pos  = 0;
    fade_over = 1'b0;
  endfunction

  function automatic void render_tick(input logic tk);
    strip_write_t w;
    int           v;
    bit           lit;
    if (!tk) return;

    // change detection on target, mode and standby entry
    if (seen_rgb != cfg_rgb) begin
      seen_rgb = cfg_rgb;
      restart_fade();
    end
    if (seen_mode != cfg_mode) begin
      seen_mode = cfg_mode;
      if (seen_mode == MODE_COLOUR) restart_fade();
    end
    if (!seen_stby && cfg_stby && seen_mode == MODE_COLOUR) restart_fade();
    seen_stby = cfg_stby;

    w = '0;
    if (seen_stby) begin
      w.whole = 1'b1;
      w.last  = 1'b1;
      pending_px.push_back(w);
      return;
    end

    case (seen_mode)
      MODE_COLOUR: begin
        if (fade_over) return;
        for (int ch = 0; ch < NCH; ch++) begin
          v = int'(fade_from[ch]) +
              (fade_pos * (int'(seen_rgb[ch]) - int'(fade_from[ch]))) / (FADE_STEPS - 1);
          shown_rgb[ch] = 8'(v);
        end
        w.rgb   = shown_rgb;
        w.whole = 1'b1;
        w.last  = 1'b1;
        pending_px.push_back(w);
        fade_pos++;
        if (fade_pos >= FADE_STEPS) begin
          fade_over = 1'b1;
          fade_pos  = 0;
        end
      end
      MODE_TWINKLE: ;
      MODE_RAINBOW: begin
        for (int i = 0; i < PIXEL_COUNT; i++) begin
          w.pix  = PIX_W'(i);
          w.rgb  = colour_wheel(8'(i * RB_STRIDE + int'(rb_off)));
          w.last = (i == PIXEL_COUNT - 1);
          pending_px.push_back(w);
        end
        rb_off++;
      end
      MODE_CYCLE: begin
        shown_rgb = colour_wheel(wheel_pos);
        w.rgb   = shown_rgb;
        w.whole = 1'b1;
        w.last  = 1'b1;
        pending_px.push_back(w);
        wheel_pos++;
      end
      default: begin
        // stripe, also taken by the unused mode codes
        for (int i = 0; i < PIXEL_COUNT; i++) begin
          lit    = (i / 8 < int'(GRID_ROWS)) && (i % 8 == stripe_col);
          w.pix  = PIX_W'(i);
          w.rgb  = lit ? {NCH{GREY_LEVEL}} : '0;
          w.last = (i == PIXEL_COUNT - 1);
          pending_px.push_back(w);
        end
        stripe_col++;
        if (stripe_col >= int'(STRIPE_WRAP)) stripe_col = 0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tick driver: offers queued ticks, random gap drawn per item.
  // Valid stays up through a stall; payload is frozen meanwhile.
  // ---------------------------------------------------------------------
  int tx_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        render_tick(tick_i);
        if (tick_i) n_ticks++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_gap != 0) begin
          tx_gap     <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_valid_i <= 1'b1;
          tick_i     <= tick_q.pop_front();
          tx_gap     <= no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor and stall generator
  // ---------------------------------------------------------------------
  int rx_gap    = 0;
  int hold_left = 0;
  int hold_seen = 0;

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    strip_write_t want;
    int           gap;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (pending_px.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual pixel %0d rgb %0d/%0d/%0d",
                   $time, pixel_index_o, red_out_o, green_out_o, blue_out_o);
          mismatches++;
        end else begin
          want = pending_px.pop_front();
          check_field("pixel_index", int'(want.pix), int'(pixel_index_o));
          check_field("red_out", int'(want.rgb[0]), int'(red_out_o));
          check_field("green_out", int'(want.rgb[1]), int'(green_out_o));
          check_field("blue_out", int'(want.rgb[2]), int'(blue_out_o));
          check_field("whole_strip", int'(want.whole), int'(whole_strip_o));
          check_field("last_of_frame", int'(want.last), int'(last_of_frame_o));
        end
      end

      // stall: long hold on request, otherwise a short random gap per result
      if (hold_seen != hold_req) begin
        hold_seen   <= hold_req;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap      <= rx_gap - 1;
        out_stall_i <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        gap         = no_idle ? 0 : $urandom_range(0, 3);
        rx_gap      <= (gap > 0) ? gap - 1 : 0;
        out_stall_i <= (gap > 0);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    n_writes++;
    case (idx)
      REG_MODE:    cfg_mode   = data[2:0];
      REG_RED:     cfg_rgb[0] = data;
      REG_GREEN:   cfg_rgb[1] = data;
      REG_BLUE:    cfg_rgb[2] = data;
      REG_STANDBY: cfg_stby   = data[0];
      default: ;  // unmapped index, no effect
    endcase
  endtask

  // queue n active ticks; optionally sprinkle in inactive ones
  task automatic queue_ticks(input int n, input bit with_idle_ticks);
    for (int i = 0; i < n; i++) begin
      if (with_idle_ticks && $urandom_range(0, 7) == 0) tick_q.push_back(1'b0);
      tick_q.push_back(1'b1);
    end
  endtask

  // wait until every tick is taken and every write seen, then idle a
  // little before the next register write
  task automatic settle();
    while (tick_q.size() != 0 || in_valid_i || pending_px.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int rand_ticks;
    int phase;
    int n;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed: reset state is stripe mode; an inactive tick first
    tick_q.push_back(1'b0);
    queue_ticks(2, 1'b0);
    settle();

    write_reg(REG_MODE, 8'(MODE_RAINBOW));
    queue_ticks(2, 1'b0);
    settle();

    write_reg(REG_MODE, 8'(MODE_CYCLE));
    queue_ticks(2, 1'b0);
    settle();

    // twinkle emits nothing
    write_reg(REG_MODE, 8'(MODE_TWINKLE));
    queue_ticks(1, 1'b0);
    settle();

    // fade from the last cycle-mode colour toward magenta
    write_reg(REG_RED, 8'hFF);
    write_reg(REG_GREEN, 8'h00);
    write_reg(REG_BLUE, 8'hFF);
    write_reg(REG_MODE, 8'(MODE_COLOUR));
    queue_ticks(3, 1'b0);
    settle();

    // standby entered while in colour mode restarts the fade
    write_reg(REG_STANDBY, 8'h01);
    queue_ticks(2, 1'b0);
    settle();

    // oversized data: only the low bits stick; mode 7 behaves as stripe
    write_reg(REG_STANDBY, 8'hFE);
    write_reg(REG_MODE, 8'hFF);
    queue_ticks(1, 1'b0);
    settle();

    write_reg(REG_MODE, 8'(MODE_STRIPE + 1));
    queue_ticks(1, 1'b0);
    settle();

    // channel extremes
    write_reg(REG_MODE, 8'(MODE_COLOUR));
    write_reg(REG_RED, 8'hFF);
    write_reg(REG_GREEN, 8'hFF);
    write_reg(REG_BLUE, 8'hFF);
    queue_ticks(2, 1'b0);
    settle();
    write_reg(REG_RED, 8'h00);
    write_reg(REG_GREEN, 8'h00);
    write_reg(REG_BLUE, 8'h00);
    queue_ticks(2, 1'b0);
    settle();

    // unmapped indexes are dropped
    for (int idx = REG_STANDBY + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), 8'($urandom));
    queue_ticks(1, 1'b0);
    settle();

    // standby out of cycle mode and back
    write_reg(REG_MODE, 8'(MODE_CYCLE));
    write_reg(REG_STANDBY, 8'h01);
    queue_ticks(1, 1'b0);
    settle();
    write_reg(REG_STANDBY, 8'h00);
    queue_ticks(1, 1'b0);
    settle();

    // --- random: first a fade run long enough to finish, then mixed phases
    write_reg(REG_MODE, 8'(MODE_COLOUR));
    write_reg(REG_RED, 8'($urandom));
    write_reg(REG_GREEN, 8'($urandom));
    write_reg(REG_BLUE, 8'($urandom));
    queue_ticks(FADE_STEPS + 2, 1'b1);
    rand_ticks = FADE_STEPS + 2;
    settle();

    phase = 0;
    while (rand_ticks < RANDOM_TICKS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        // fill the block: stripe ticks behind a long output hold-off
        write_reg(REG_STANDBY, 8'h00);
        write_reg(REG_MODE, 8'(MODE_STRIPE));
        hold_req++;
        n = 6;
      end else begin
        if ($urandom_range(0, 1))
          write_reg(REG_MODE, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 4)));
        if ($urandom_range(0, 2) == 0) write_reg(REG_RED, 8'($urandom));
        if ($urandom_range(0, 2) == 0) write_reg(REG_GREEN, 8'($urandom));
        if ($urandom_range(0, 2) == 0) write_reg(REG_BLUE, 8'($urandom));
        if ($urandom_range(0, 2) == 0)
          write_reg(REG_STANDBY, ($urandom_range(0, 2) == 0) ? 8'($urandom | 1) : 8'($urandom & 8'hFE));
        if ($urandom_range(0, 9) == 0)
          write_reg(CFG_IDX_W'($urandom_range(REG_STANDBY + 1, (1 << CFG_IDX_W) - 1)), 8'($urandom));
        n = $urandom_range(2, 8);
      end
      queue_ticks(n, 1'b1);
      rand_ticks += n;
      phase++;
      settle();
    end

    $display("Covered %0d ticks over %0d phases, %0d strip writes checked, %0d register writes.",
             n_ticks, phase, n_results, n_writes);
    $display("Modes colour/twinkle/rainbow/cycle/stripe, standby, unmapped codes and a long hold-off.");
    if (mismatches == 0) begin
      $display("tb_led_strip_effect_generator: PASS");
    end else begin
      $display("tb_led_strip_effect_generator: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d strip writes still expected", $time, pending_px.size());
    $display("tb_led_strip_effect_generator: FAIL");
    $finish;
  end

endmodule
